FILE: rtl/mat_pkg.sv
// shared types and character codes for the markup attribute tokenizer
`default_nettype none

package mat_pkg;

    localparam int QDEPTH = 4;

    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BS    = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_SEEK  = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    localparam logic [1:0] K_NAME     = 2'd0;
    localparam logic [1:0] K_VALUE    = 2'd1;
    localparam logic [1:0] K_ATTR_END = 2'd2;
    localparam logic [1:0] K_LIST_END = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic       simple_tag;
        logic       last;
    } t_result;

    function automatic logic closes_simple(input logic [7:0] p);
        closes_simple = (p == CH_SLASH) || (p == CH_DASH);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/markup_attribute_tokenizer.sv
// markup attribute tokenizer: one tag byte in, up to two tokens out per beat
// output: tokens are written into a registered result queue and presented from its head
// throughput: one input beat per cycle while the input is not stalled; a four-entry result queue absorbs
//   two-token beats and stalls the input only while more than two tokens wait
// reset: synchronous active-low; phase returns to name, queue empties
`default_nettype none

module markup_attribute_tokenizer
    import mat_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_byte_req,
    input  wire logic       i_end_of_input,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_char_out,
    output logic            o_simple_tag,
    output logic            o_last
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_phase     r_phase, n_phase;
    logic [7:0] r_prev, n_prev;
    logic [7:0] r_quote, n_quote;
    logic       r_name_started, n_name_started;

    t_result    r_queue [QDEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    logic       in_acc, out_acc;
    t_result    res0, res1;
    logic [1:0] res_cnt;
    logic       is_ws, is_gt, is_bs, p_bs;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign is_ws   = (i_byte_req == CH_SP) || (i_byte_req == CH_LF) || (i_byte_req == CH_TAB);
    assign is_gt   = (i_byte_req == CH_GT);
    assign is_bs   = (i_byte_req == CH_BS);
    assign p_bs    = (r_prev == CH_BS);

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_prev         = r_prev;
        n_quote        = r_quote;
        n_name_started = r_name_started;
        if (in_acc) begin
            if (i_end_of_input) begin
                n_phase        = PH_NAME;
                n_prev         = '0;
                n_quote        = '0;
                n_name_started = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_SEEK: begin
                        if (i_byte_req == CH_DQ || i_byte_req == CH_SQ) begin
                            n_quote = i_byte_req;
                            n_phase = PH_VALUE;
                            n_prev  = '0;
                        end else if (is_gt) begin
                            n_phase        = PH_NAME;
                            n_prev         = '0;
                            n_quote        = '0;
                            n_name_started = 1'b0;
                        end else begin
                            n_prev = i_byte_req;
                        end
                    end
                    PH_VALUE: begin
                        if ((is_gt && !p_bs) || (i_byte_req == r_quote)) begin
                            n_phase        = PH_NAME;
                            n_prev         = '0;
                            n_quote        = '0;
                            n_name_started = 1'b0;
                        end else if ((is_bs || is_gt) && p_bs) begin
                            n_prev = '0;
                        end else begin
                            n_prev = i_byte_req;
                        end
                    end
                    default: begin
                        if (is_gt || (i_byte_req == CH_EQ && !r_name_started)) begin
                            n_phase        = PH_NAME;
                            n_prev         = '0;
                            n_quote        = '0;
                            n_name_started = 1'b0;
                        end else if (i_byte_req == CH_EQ) begin
                            n_phase = PH_SEEK;
                            n_prev  = i_byte_req;
                        end else begin
                            if (!is_ws) begin
                                n_name_started = 1'b1;
                            end
                            n_prev = i_byte_req;
                        end
                    end
                endcase
            end
        end
    end

    // tokens for the current beat
    always_comb begin
        res0    = '0;
        res1    = '0;
        res_cnt = 2'd0;
        if (i_end_of_input) begin
            if (r_phase != PH_NAME || r_name_started) begin
                res0.kind = K_ATTR_END;
                res1.kind = K_LIST_END;
                res_cnt   = 2'd2;
            end else begin
                res0.kind = K_LIST_END;
                res_cnt   = 2'd1;
            end
        end else begin
            unique case (r_phase)
                PH_SEEK: begin
                    if (is_gt) begin
                        res0.kind       = K_ATTR_END;
                        res1.kind       = K_LIST_END;
                        res1.simple_tag = closes_simple(r_prev);
                        res_cnt         = 2'd2;
                    end
                end
                PH_VALUE: begin
                    if (is_gt && !p_bs) begin
                        res0.kind       = K_ATTR_END;
                        res1.kind       = K_LIST_END;
                        res1.simple_tag = closes_simple(r_prev);
                        res_cnt         = 2'd2;
                    end else if (i_byte_req == r_quote) begin
                        res0.kind = K_ATTR_END;
                        res_cnt   = 2'd1;
                    end else if (i_byte_req == CH_LF || i_byte_req == CH_TAB) begin
                        res_cnt = 2'd0;
                    end else if (is_bs && !p_bs) begin
                        res_cnt = 2'd0;
                    end else if ((is_bs || is_gt) && p_bs) begin
                        res0.kind     = K_VALUE;
                        res0.char_out = i_byte_req;
                        res_cnt       = 2'd1;
                    end else if (p_bs) begin
                        res0.kind     = K_VALUE;
                        res0.char_out = CH_BS;
                        res1.kind     = K_VALUE;
                        res1.char_out = i_byte_req;
                        res_cnt       = 2'd2;
                    end else begin
                        res0.kind     = K_VALUE;
                        res0.char_out = i_byte_req;
                        res_cnt       = 2'd1;
                    end
                end
                default: begin
                    if (is_gt) begin
                        if (r_name_started) begin
                            res0.kind       = K_ATTR_END;
                            res1.kind       = K_LIST_END;
                            res1.simple_tag = closes_simple(r_prev);
                            res_cnt         = 2'd2;
                        end else begin
                            res0.kind       = K_LIST_END;
                            res0.simple_tag = closes_simple(r_prev);
                            res_cnt         = 2'd1;
                        end
                    end else if (i_byte_req == CH_EQ) begin
                        if (!r_name_started) begin
                            res0.kind = K_LIST_END;
                            res_cnt   = 2'd1;
                        end
                    end else if (!is_ws) begin
                        res0.kind     = K_NAME;
                        res0.char_out = i_byte_req;
                        res_cnt       = 2'd1;
                    end
                end
            endcase
        end
        res0.last = (res_cnt == 2'd1);
        res1.last = (res_cnt == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_NAME;
            r_prev         <= '0;
            r_quote        <= '0;
            r_name_started <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_prev         <= n_prev;
            r_quote        <= n_quote;
            r_name_started <= n_name_started;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (in_acc && res_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (in_acc && res_cnt == 2'd2) begin
            r_queue[r_wr_ptr + PW'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_wr_ptr <= r_wr_ptr + PW'(res_cnt);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + (in_acc ? CW'(res_cnt) : CW'(0)) - (out_acc ? CW'(1) : CW'(0));
        end
    end

    assign o_in_stall   = (r_count > CW'(QDEPTH - 2));
    assign o_out_valid  = (r_count != '0);
    assign o_kind       = r_queue[r_rd_ptr].kind;
    assign o_char_out   = r_queue[r_rd_ptr].char_out;
    assign o_simple_tag = r_queue[r_rd_ptr].simple_tag;
    assign o_last       = r_queue[r_rd_ptr].last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QDEPTH))
        else $error("result queue overflow");

    a_eoi_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_end_of_input |=> r_phase == PH_NAME && !r_name_started)
        else $error("end of input did not reset the tokenizer");

    a_attr_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_NAME |-> r_name_started)
        else $error("seek or value phase without a name");

    a_list_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == K_LIST_END |-> o_last)
        else $error("list end is not the final token of its beat");
`endif

endmodule

`default_nettype wire
